FILE: src/bfs_pkg.sv
// ----------------------------------------------------------------------------
// BFS engine package
// Shared opcodes, status codes and field widths.
// ----------------------------------------------------------------------------
package bfs_pkg;
   localparam int VertexBits = 6;
   localparam int OpBits     = 2;
   localparam int StatusBits = 2;
   localparam int CountBits  = 7;

   typedef enum logic [OpBits-1:0] {
      OP_ADD_EDGE = 2'd0,
      OP_FIND     = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [StatusBits-1:0] {
      ST_OK          = 2'd0,
      ST_UNREACHABLE = 2'd1,
      ST_FULL        = 2'd2,
      ST_RANGE       = 2'd3
   } status_type;

   typedef struct packed {
      op_type                op;
      logic [VertexBits-1:0] from_vertex;
      logic [VertexBits-1:0] to_vertex;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [VertexBits-1:0] hop_count;
      logic [VertexBits-1:0] path_vertex;
      logic                  last;
   } rsp_type;
endpackage

FILE: src/bfs_if.sv
// ----------------------------------------------------------------------------
// BFS stream interfaces
// Valid/ready channels for requests, responses and the count register.
// ----------------------------------------------------------------------------
interface bfs_req_if;
   import bfs_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bfs_rsp_if;
   import bfs_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bfs_csr_if;
   import bfs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CountBits-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/bfs_shortest_path_engine_unit.sv
// ----------------------------------------------------------------------------
// BFS shortest path engine
// Directed graph store with breadth-first shortest path search.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | transfer
//  req     | in  | op, from_vertex, to_vertex            | valid & ready
//  rsp     | out | status, hop_count, path_vertex, last  | valid & ready
//  csr     | in  | vertex_count (7 bits)                 | valid & ready
//
// Add edge answers once the edge is appended; clear sweeps MAX_VERTICES
// list heads first. A search first sweeps the marks of all MAX_VERTICES
// vertices, then dequeues each vertex (DEQ, HEAD, LOAD), scans each edge
// (EDGE, TGT, VISIT) and closes each list in EDGE (one edge memory port),
// then walks the parent chain (WALK, PARENT) and sends each path vertex
// (EMIT, SEND). After reset the list heads are swept clear before the first
// request. One request at a time; the response register holds under rsp stall.
module bfs_shortest_path_engine_unit #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 512
) (
   input logic clock,
   input logic reset,
   bfs_req_if.sink   req,
   bfs_rsp_if.source rsp,
   bfs_csr_if.sink   csr
);
   import bfs_pkg::*;

   localparam int VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EW = $clog2(MAX_EDGES + 1);
   localparam int VW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [16:0] {
      S_INIT   = 17'h00001,
      S_IDLE   = 17'h00002,
      S_DEC    = 17'h00004,
      S_ADD    = 17'h00008,
      S_CLR    = 17'h00010,
      S_SCLR   = 17'h00020,
      S_DEQ    = 17'h00040,
      S_HEAD   = 17'h00080,
      S_LOAD   = 17'h00100,
      S_EDGE   = 17'h00200,
      S_TGT    = 17'h00400,
      S_VISIT  = 17'h00800,
      S_CHECK  = 17'h01000,
      S_WALK   = 17'h02000,
      S_PARENT = 17'h04000,
      S_EMIT   = 17'h08000,
      S_SEND   = 17'h10000
   } state_type;

   // memories
   logic [VertexBits-1:0] tgt_mem  [MAX_EDGES];
   logic [EW-1:0]         link_mem [MAX_EDGES];
   logic [EW-1:0]         head_mem [MAX_VERTICES];
   logic [EA-1:0]         tail_mem [MAX_VERTICES];
   logic [1:0]            mark_mem [MAX_VERTICES];
   logic [VA-1:0]         par_mem  [MAX_VERTICES];
   logic [VertexBits-1:0] dist_mem [MAX_VERTICES];
   logic [VA-1:0]         q_mem    [MAX_VERTICES];
   logic [VA-1:0]         stk_mem  [MAX_VERTICES];

   state_type state_ff;
   logic [CountBits-1:0] vcount_ff;
   logic [EW-1:0] used_ff;
   req_type req_ff;
   logic [VW-1:0] idx_ff;           // sweep index / queue head / depth
   logic [VW-1:0] qt_ff;
   logic [VA-1:0] u_ff;
   logic [VertexBits-1:0] du_ff;
   logic [EW-1:0] e_ff;
   logic [EW-1:0] guard_ff;
   logic [VA-1:0] cur_ff;
   logic [VertexBits-1:0] hops_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   // registered memory reads
   logic [EW-1:0] head_rd_ff;
   logic [EA-1:0] tail_rd_ff;
   logic [VertexBits-1:0] tgt_rd_ff;
   logic [EW-1:0] link_rd_ff;
   logic [1:0] mark_rd_ff;
   logic [VA-1:0] par_rd_ff;
   logic [VertexBits-1:0] dist_rd_ff;
   logic [VA-1:0] q_rd_ff;
   logic [VA-1:0] stk_rd_ff;
   logic [VA-1:0] head_ra, mark_ra, par_ra, dist_ra, q_ra, stk_ra;
   logic [EA-1:0] edge_ra;
   logic [VW-1:0] n_act;
   logic fa_ok, fb_ok;

   assign n_act = (vcount_ff > CountBits'(MAX_VERTICES)) ? VW'(MAX_VERTICES)
                                                         : VW'(vcount_ff);
   assign fa_ok = {1'b0, req_ff.from_vertex} < (VertexBits+1)'(n_act);
   assign fb_ok = {1'b0, req_ff.to_vertex}   < (VertexBits+1)'(n_act);

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // read address selection
   always_comb begin
      head_ra = VA'(req_ff.from_vertex);
      edge_ra = e_ff[EA-1:0];
      mark_ra = VA'(tgt_rd_ff);
      par_ra  = cur_ff;
      dist_ra = VA'(req_ff.to_vertex);
      q_ra    = idx_ff[VA-1:0];
      stk_ra  = idx_ff[VA-1:0];
      if (state_ff == S_HEAD) begin
         head_ra = q_rd_ff;
         dist_ra = q_rd_ff;
      end
      if (state_ff == S_EMIT || state_ff == S_SEND) stk_ra = VA'(idx_ff - VW'(1));
   end

   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[head_ra];
      tail_rd_ff <= tail_mem[head_ra];
      tgt_rd_ff  <= tgt_mem[edge_ra];
      link_rd_ff <= link_mem[edge_ra];
      mark_rd_ff <= mark_mem[mark_ra];
      par_rd_ff  <= par_mem[par_ra];
      dist_rd_ff <= dist_mem[dist_ra];
      q_rd_ff    <= q_mem[q_ra];
      stk_rd_ff  <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         idx_ff       <= '0;
         vcount_ff    <= CountBits'(64);
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) vcount_ff <= csr.data;
         if (rsp_valid_ff && rsp.ready && state_ff != S_SEND) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_INIT: begin
               head_mem[idx_ff[VA-1:0]] <= EW'(MAX_EDGES);
               idx_ff <= idx_ff + VW'(1);
               if (idx_ff == VW'(MAX_VERTICES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  req_ff   <= req.data;
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               // head/tail of from_vertex are read at the end of this cycle
               idx_ff <= '0;
               unique case (req_ff.op)
                  OP_NONE: state_ff <= S_IDLE;
                  OP_CLEAR: state_ff <= S_CLR;
                  default: begin
                     if (!fa_ok || !fb_ok) begin
                        rsp_ff       <= '{ST_RANGE, '0, '0, 1'b1};
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else if (req_ff.op == OP_ADD_EDGE) begin
                        if (used_ff >= EW'(MAX_EDGES)) begin
                           rsp_ff       <= '{ST_FULL, '0, '0, 1'b1};
                           rsp_valid_ff <= 1'b1;
                           state_ff     <= S_IDLE;
                        end else begin
                           tgt_mem[used_ff[EA-1:0]]  <= req_ff.to_vertex;
                           link_mem[used_ff[EA-1:0]] <= EW'(MAX_EDGES);
                           state_ff <= S_ADD;
                        end
                     end else begin
                        state_ff <= S_SCLR;
                     end
                  end
               endcase
            end
            S_ADD: begin
               // append the new edge to the list of from_vertex
               if (head_rd_ff == EW'(MAX_EDGES))
                  head_mem[VA'(req_ff.from_vertex)] <= used_ff;
               else
                  link_mem[tail_rd_ff] <= used_ff;
               tail_mem[VA'(req_ff.from_vertex)] <= used_ff[EA-1:0];
               used_ff      <= used_ff + EW'(1);
               rsp_ff       <= '{ST_OK, '0, '0, 1'b1};
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_CLR: begin
               head_mem[idx_ff[VA-1:0]] <= EW'(MAX_EDGES);
               idx_ff <= idx_ff + VW'(1);
               used_ff <= '0;
               if (idx_ff == VW'(MAX_VERTICES - 1)) begin
                  rsp_ff       <= '{ST_OK, '0, '0, 1'b1};
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_SCLR: begin
               // the sweep marks the source as queued
               mark_mem[idx_ff[VA-1:0]] <=
                  (idx_ff[VA-1:0] == VA'(req_ff.from_vertex)) ? 2'd1 : 2'd0;
               dist_mem[idx_ff[VA-1:0]] <= '0;
               par_mem[idx_ff[VA-1:0]]  <= '0;
               if (idx_ff == VW'(MAX_VERTICES - 1)) begin
                  q_mem[0] <= VA'(req_ff.from_vertex);
                  idx_ff   <= '0;
                  qt_ff    <= VW'(1);
                  state_ff <= S_DEQ;
               end else begin
                  idx_ff <= idx_ff + VW'(1);
               end
            end
            S_DEQ: begin
               // q_rd_ff valid next cycle
               if (idx_ff >= qt_ff) begin
                  state_ff <= S_CHECK;
               end else begin
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               u_ff     <= q_rd_ff;
               state_ff <= S_LOAD;
               guard_ff <= '0;
               idx_ff   <= idx_ff + VW'(1);
            end
            S_LOAD: begin
               e_ff     <= head_rd_ff;
               du_ff    <= dist_rd_ff;
               state_ff <= S_EDGE;
            end
            S_EDGE: begin
               if (e_ff < EW'(MAX_EDGES) && e_ff < used_ff
                   && guard_ff < EW'(MAX_EDGES)) begin
                  state_ff <= S_TGT;
               end else begin
                  mark_mem[u_ff] <= 2'd2;
                  state_ff <= S_DEQ;
               end
            end
            S_TGT: state_ff <= S_VISIT;
            S_VISIT: begin
               // tgt_rd_ff/link_rd_ff hold edge e, mark_rd_ff its target mark
               if ({1'b0, tgt_rd_ff} < (VertexBits+1)'(n_act)
                   && mark_rd_ff == 2'd0
                   && qt_ff < VW'(MAX_VERTICES)) begin
                  dist_mem[VA'(tgt_rd_ff)] <= du_ff + VertexBits'(1);
                  par_mem[VA'(tgt_rd_ff)]  <= u_ff;
                  mark_mem[VA'(tgt_rd_ff)] <= 2'd1;
                  q_mem[qt_ff[VA-1:0]]     <= VA'(tgt_rd_ff);
                  qt_ff <= qt_ff + VW'(1);
               end
               e_ff     <= link_rd_ff;
               guard_ff <= guard_ff + EW'(1);
               state_ff <= S_EDGE;
            end
            S_CHECK: begin
               if (req_ff.to_vertex != req_ff.from_vertex
                   && dist_rd_ff == '0) begin
                  rsp_ff        <= '{ST_UNREACHABLE, '0, '0, 1'b1};
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  hops_ff <= (req_ff.to_vertex == req_ff.from_vertex) ? '0
                                                                       : dist_rd_ff;
                  stk_mem[0] <= VA'(req_ff.to_vertex);
                  cur_ff   <= VA'(req_ff.to_vertex);
                  idx_ff   <= VW'(1);
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               // parent of cur_ff is read at the end of this cycle
               if (cur_ff == VA'(req_ff.from_vertex)
                   || idx_ff >= VW'(MAX_VERTICES)) begin
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_PARENT;
               end
            end
            S_PARENT: begin
               stk_mem[idx_ff[VA-1:0]] <= par_rd_ff;
               cur_ff   <= par_rd_ff;
               idx_ff   <= idx_ff + VW'(1);
               state_ff <= S_WALK;
            end
            S_EMIT: state_ff <= S_SEND;
            S_SEND: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_ff       <= '{ST_OK, hops_ff, VertexBits'(stk_rd_ff),
                                    idx_ff == VW'(1)};
                  rsp_valid_ff <= 1'b1;
                  idx_ff       <= idx_ff - VW'(1);
                  state_ff     <= (idx_ff == VW'(1)) ? S_IDLE : S_EMIT;
               end
            end
            default: state_ff <= S_INIT;
         endcase
      end
   end
endmodule

FILE: src/bfs_checker.sv
// ----------------------------------------------------------------------------
// BFS engine port checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
module bfs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   // no new request while a response is still waiting
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during response");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   // request transfer closes the ready window
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after transfer");
   a_last_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_last)) else $error("last changed");
endmodule

bind bfs_shortest_path_engine_unit bfs_checker u_bfs_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_last(rsp.data.last)
);

FILE: test/bfs_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BFS engine path predictor
// Keeps a copy of the graph store and the vertex count register. For every
// accepted request it computes the responses the engine must produce and
// holds them in order for comparison against the response channel.
// ----------------------------------------------------------------------------
package bfs_tb_pkg;
   import bfs_pkg::*;

   localparam int NumVertices = 64;
   localparam int NumEdges    = 512;
   localparam int EmptyLink   = NumEdges;
   localparam int NoParent    = NumVertices;

   class bfs_path_predictor;
      int unsigned vertex_limit;
      int unsigned edge_dest [NumEdges];
      int unsigned edge_next [NumEdges];
      int unsigned head [NumVertices];
      int unsigned tail [NumVertices];
      int unsigned edge_total;
      rsp_type     pending_rsps [$];
      int unsigned error_count;

      function new();
         vertex_limit = NumVertices;
         error_count  = 0;
         wipe_graph();
      endfunction

      function void wipe_graph();
         for (int i = 0; i < NumVertices; i++) begin
            head[i] = EmptyLink;
            tail[i] = 0;
         end
         edge_total = 0;
      endfunction

      function void set_vertex_count(logic [CountBits-1:0] value);
         vertex_limit = (value > NumVertices) ? NumVertices : value;
      endfunction

      function void push_rsp(status_type st, int unsigned hops, int unsigned vtx, bit lst);
         rsp_type r;
         r.status      = st;
         r.hop_count   = hops[VertexBits-1:0];
         r.path_vertex = vtx[VertexBits-1:0];
         r.last        = lst;
         pending_rsps.push_back(r);
      endfunction

      function void note_request(req_type rq);
         int unsigned src, dst, e, qh, qt, u, w, guard, cur, depth;
         int unsigned mark [NumVertices];
         int unsigned parent [NumVertices];
         int unsigned level [NumVertices];
         int unsigned queue [NumVertices];
         int unsigned stack [NumVertices];
         src = rq.from_vertex;
         dst = rq.to_vertex;
         if (rq.op == OP_NONE) return;
         if (rq.op == OP_CLEAR) begin
            wipe_graph();
            push_rsp(ST_OK, 0, 0, 1);
            return;
         end
         if (src >= vertex_limit || dst >= vertex_limit) begin
            push_rsp(ST_RANGE, 0, 0, 1);
            return;
         end
         if (rq.op == OP_ADD_EDGE) begin
            e = edge_total;
            if (e >= NumEdges) begin
               push_rsp(ST_FULL, 0, 0, 1);
               return;
            end
            edge_dest[e] = dst;
            edge_next[e] = EmptyLink;
            if (head[src] == EmptyLink) head[src] = e;
            else if (tail[src] < NumEdges) edge_next[tail[src]] = e;
            tail[src]  = e;
            edge_total = e + 1;
            push_rsp(ST_OK, 0, 0, 1);
            return;
         end
         // breadth-first search, neighbors in insertion order
         for (int i = 0; i < NumVertices; i++) begin
            mark[i] = 0; parent[i] = NoParent; level[i] = 0;
         end
         qh = 0; qt = 0;
         mark[src] = 1;
         queue[qt++] = src;
         while (qh < qt) begin
            u = queue[qh++];
            e = head[u];
            guard = 0;
            while (e < NumEdges && e < edge_total && guard < NumEdges) begin
               w = edge_dest[e];
               if (w < vertex_limit && mark[w] == 0 && qt < NumVertices) begin
                  level[w] = (level[u] + 1) % 64;
                  parent[w] = u;
                  mark[w] = 1;
                  queue[qt++] = w;
               end
               e = edge_next[e];
               guard++;
            end
            mark[u] = 2;
         end
         if (dst != src && level[dst] == 0) begin
            push_rsp(ST_UNREACHABLE, 0, 0, 1);
            return;
         end
         depth = 0; cur = dst;
         stack[depth++] = dst;
         while (cur != src && depth < NumVertices) begin
            if (parent[cur] >= NumVertices) break;
            stack[depth++] = parent[cur];
            cur = parent[cur];
         end
         for (int k = 0; k < depth; k++)
            push_rsp(ST_OK, (dst == src) ? 0 : level[dst], stack[depth-1-k], k + 1 == depth);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_rsps.size() == 0) begin
            $error("unexpected response %p", got);
            error_count++;
            return;
         end
         want = pending_rsps.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            error_count++;
         end
         if (got.hop_count !== want.hop_count) begin
            $error("hop_count: expected %0d, actual %0d", want.hop_count, got.hop_count);
            error_count++;
         end
         if (got.path_vertex !== want.path_vertex) begin
            $error("path_vertex: expected %0d, actual %0d", want.path_vertex,
                   got.path_vertex);
            error_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            error_count++;
         end
      endfunction
   endclass
endpackage

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BFS engine testbench
// Builds graphs through add-edge requests, runs path searches under several
// vertex counts and checks every response against a local path predictor,
// with random idle bursts on the request and response channels.
// ----------------------------------------------------------------------------
module testbench;
   import bfs_pkg::*;
   import bfs_tb_pkg::*;

   localparam int WatchdogLimit = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;
   int unsigned idle_cycles = 0;

   bfs_req_if req ();
   bfs_rsp_if rsp ();
   bfs_csr_if csr ();

   bfs_path_predictor path_model = new();

   bfs_shortest_path_engine_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   always #1 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.data  = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.data  = '0;
   end

   // response side: check each transfer, stall in random bursts
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) path_model.check_response(rsp.data);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            if (rsp.valid && rsp.ready) path_model.check_response(rsp.data);
         end
         rsp.ready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_request(op_type op, int unsigned src, int unsigned dst);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req.valid            <= 1'b1;
      req.data.op          <= op;
      req.data.from_vertex <= src[VertexBits-1:0];
      req.data.to_vertex   <= dst[VertexBits-1:0];
      do @(posedge clock); while (!req.ready);
      path_model.note_request(req.data);
      req.valid <= 1'b0;
      // the engine is busy after a transfer anyway
      @(posedge clock);
   endtask

   task automatic drain();
      while (path_model.pending_rsps.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // idle-only register write
   task automatic write_vertex_count(int unsigned value);
      drain();
      csr.valid <= 1'b1;
      csr.data  <= value[CountBits-1:0];
      do @(posedge clock); while (!csr.ready);
      path_model.set_vertex_count(csr.data);
      csr.valid <= 1'b0;
   endtask

   function automatic op_type random_op();
      int unsigned pick = $urandom_range(0, 19);
      if (pick < 11) return OP_ADD_EDGE;
      if (pick < 18) return OP_FIND;
      if (pick < 19) return OP_CLEAR;
      return OP_NONE;
   endfunction

   // random phase mostly on the given vertex span; a small span lets paths form
   task automatic random_phase(int unsigned count, int unsigned span);
      op_type op;
      for (int i = 0; i < count; i++) begin
         op = random_op();
         if ($urandom_range(0, 9) == 0)
            send_request(op, $urandom_range(0, 63), $urandom_range(0, 63));
         else
            send_request(op, $urandom_range(0, span - 1), $urandom_range(0, span - 1));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: chain, self path, unreachable, top vertex 63, clear, ignored op
      for (int v = 0; v < 5; v++) send_request(OP_ADD_EDGE, v, v + 1);
      send_request(OP_ADD_EDGE, 0, 3);
      send_request(OP_ADD_EDGE, 0, 3);
      send_request(OP_ADD_EDGE, 63, 0);
      send_request(OP_FIND, 0, 5);
      send_request(OP_FIND, 63, 5);
      send_request(OP_FIND, 4, 4);
      send_request(OP_FIND, 5, 0);
      send_request(OP_NONE, 63, 63);
      send_request(OP_CLEAR, 0, 0);
      send_request(OP_FIND, 0, 5);

      // shrink the count below vertices that have edges
      for (int v = 0; v < 6; v++) send_request(OP_ADD_EDGE, v, v + 1);
      write_vertex_count(4);
      send_request(OP_ADD_EDGE, 63, 1);
      send_request(OP_FIND, 0, 3);
      send_request(OP_FIND, 0, 5);
      write_vertex_count(0);
      send_request(OP_FIND, 0, 0);
      send_request(OP_ADD_EDGE, 0, 0);
      write_vertex_count(127);
      send_request(OP_FIND, 0, 6);

      // fill the store with random edges, search along the way, then overflow
      send_request(OP_CLEAR, 0, 0);
      write_vertex_count(12);
      for (int i = 0; i < 513; i++) begin
         send_request(OP_ADD_EDGE, $urandom_range(0, 11), $urandom_range(0, 11));
         if (i % 32 == 31)
            send_request(OP_FIND, $urandom_range(0, 11), $urandom_range(0, 11));
      end
      send_request(OP_FIND, 0, 0);
      send_request(OP_FIND, 0, 11);
      write_vertex_count(64);
      send_request(OP_CLEAR, 0, 0);

      // long path through all 64 vertices
      for (int v = 63; v > 0; v--) send_request(OP_ADD_EDGE, v, v - 1);
      send_request(OP_FIND, 63, 0);
      send_request(OP_CLEAR, 0, 0);

      random_phase(30, 12);
      write_vertex_count(2);
      random_phase(15, 2);
      write_vertex_count(64);
      random_phase(25, 64);
      calm = 1'b1;
      random_phase(20, 10);

      drain();
      if (path_model.error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

FILE: filelist.f
src/bfs_pkg.sv
src/bfs_if.sv
src/bfs_shortest_path_engine_unit.sv
src/bfs_checker.sv
test/bfs_scoreboard.sv
test/testbench.sv
